FILE: rtl/core/cgs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgs_pkg
// shared types, opcodes and fixed point helpers for the vector update unit
// ----------------------------------------------------------------------------
package cgs_pkg;

    localparam int COLUMNS_DEF       = 8;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int WORD_W            = 32;
    localparam int QDEPTH            = 2;

    typedef enum logic [2:0] {
        OP_RESET = 3'd0,
        OP_BETA  = 3'd1,
        OP_ALPHA = 3'd2,
        OP_STEP1 = 3'd3,
        OP_STEP2 = 3'd4,
        OP_STEP3 = 3'd5,
        OP_UNUSED6 = 3'd6,
        OP_UNUSED7 = 3'd7
    } t_opcode;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [2:0]         column;
        logic               stopped;
        logic signed [31:0] rho_value;
        logic signed [31:0] divisor_value;
        logic signed [31:0] vec_a;
        logic signed [31:0] vec_b;
        logic signed [31:0] vec_c;
        logic signed [31:0] vec_d;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] first_out;
        logic signed [31:0] second_out;
        logic               skipped;
        logic               saturated;
    } t_out_item;

    // back part sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_M5,
        ST_DIV,
        ST_DONE
    } t_state;

    // clip a 66 bit value to a signed word
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v,
                                                 output logic flag);
        flag = 1'b0;
        if (v > 66'sd2147483647) begin
            flag = 1'b1;
            return 32'sh7fffffff;
        end
        if (v < -66'sd2147483648) begin
            flag = 1'b1;
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

FILE: rtl/core/cgs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgs_front
// input stage and short queue feeding the back part
// ----------------------------------------------------------------------------
module cgs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cgs_pkg::t_in_item i_in_data,
    output logic              o_q_valid,
    input  logic              i_q_pop,
    output cgs_pkg::t_in_item o_q_data
);
    import cgs_pkg::*;

    t_in_item r_mem [QDEPTH];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push;

    assign o_in_ready = (r_cnt != 2'(QDEPTH));
    assign push       = i_in_valid && o_in_ready;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_data   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp + 1'(push);
        n_rp  = r_rp + 1'(i_q_pop);
        n_cnt = r_cnt + 2'(push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_in_data;
        end
    end
endmodule

FILE: rtl/core/cgs_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgs_div
// restoring divider, one quotient bit per cycle, truncation toward zero
// ----------------------------------------------------------------------------
module cgs_div #(
    parameter int FRACTION_BITS = cgs_pkg::FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [65:0] o_quot
);
    import cgs_pkg::*;

    localparam int NW = 32 + FRACTION_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q, n_q;
    logic [31:0]   r_d, n_d;
    logic [32:0]   r_rem, n_rem;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy;
    logic          r_neg, n_neg;
    logic          r_done, n_done;
    logic [32:0]   trial;
    logic [NW-1:0] num_mag;
    logic [65:0]   mag_ext;

    always_comb begin
        num_mag = i_num[31] ? NW'(-{{(NW-32){i_num[31]}}, i_num}) << FRACTION_BITS
                            : NW'({{(NW-32){1'b0}}, i_num}) << FRACTION_BITS;
        n_q = r_q; n_d = r_d; n_rem = r_rem; n_cnt = r_cnt;
        n_busy = r_busy; n_neg = r_neg; n_done = 1'b0;
        trial = {r_rem[31:0], r_q[NW-1]} - {1'b0, r_d};
        if (i_start) begin
            n_q    = num_mag;
            n_d    = i_den[31] ? 32'(-i_den) : 32'(i_den);
            n_rem  = '0;
            n_cnt  = CW'(NW);
            n_busy = 1'b1;
            n_neg  = i_num[31] ^ i_den[31];
        end else if (r_busy) begin
            if (!trial[32]) begin
                n_rem = trial;
            end else begin
                n_rem = {r_rem[31:0], r_q[NW-1]};
            end
            n_q   = {r_q[NW-2:0], ~trial[32]};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign mag_ext = 66'(r_q);
    assign o_quot  = r_neg ? -$signed(mag_ext) : $signed(mag_ext);
    assign o_done  = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_d   <= n_d;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
        r_neg <= n_neg;
    end
endmodule

FILE: rtl/core/cgs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgs_back
// scalar store, multiply sequencer and divider control
// ----------------------------------------------------------------------------
module cgs_back #(
    parameter int COLUMNS       = cgs_pkg::COLUMNS_DEF,
    parameter int FRACTION_BITS = cgs_pkg::FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    output logic               o_q_pop,
    input  cgs_pkg::t_in_item  i_q_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cgs_pkg::t_out_item o_out_data
);
    import cgs_pkg::*;

    localparam int CIW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam logic signed [31:0] ONE = 32'sd1 <<< FRACTION_BITS;

    t_state r_state, n_state;
    t_in_item r_it;
    logic signed [31:0] r_beta [COLUMNS];
    logic signed [31:0] r_alpha [COLUMNS];
    logic [CIW-1:0] r_col;
    logic signed [31:0] r_scal;
    logic signed [31:0] r_t0, r_t1;
    logic signed [63:0] r_prod;
    logic               r_sat;
    logic               r_skip;
    t_out_item          r_out;
    logic               r_ov;

    logic [3:0]     col_wrap;
    logic [CIW-1:0] col_in;
    logic signed [31:0] mul_x, mul_y;
    logic signed [65:0] rnd;
    logic signed [31:0] mr, s0, s1;
    logic f0, f1, f2, fd;
    logic signed [31:0] dq;
    logic div_start, div_done;
    logic signed [65:0] quot;
    logic can_out;
    logic stop;
    logic [2:0] op;

    cgs_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(r_it.rho_value), .i_den(r_it.divisor_value),
        .o_done(div_done), .o_quot(quot)
    );

    // wrap the column into range by repeated subtraction
    always_comb begin
        col_wrap = {1'b0, i_q_data.column};
        for (int k = 0; k < 7; k++) begin
            if (COLUMNS < 8 && col_wrap >= 4'(COLUMNS)) begin
                col_wrap = col_wrap - 4'(COLUMNS);
            end
        end
    end

    assign col_in  = CIW'(col_wrap);
    assign can_out = !r_ov || i_out_ready;
    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid;
    assign op      = r_it.opcode;
    assign stop    = r_it.stopped;

    // rounded product from the previous multiply stage
    assign rnd = (66'(r_prod) + (66'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    always_comb begin
        mr = sat32(rnd, f0);
        // operand selection per step
        mul_x = r_scal;
        mul_y = r_it.vec_b;
        unique case (r_state)
            ST_M1:   mul_y = (op == OP_STEP3) ? r_it.vec_d : r_it.vec_b;
            ST_M2:   mul_y = (op == OP_STEP3) ? r_it.vec_b : r_it.vec_c;
            ST_M4:   mul_y = r_t1;
            default: mul_y = r_it.vec_b;
        endcase
        s0 = '0; s1 = '0; f1 = 1'b0; f2 = 1'b0;
        unique case (r_state)
            ST_M2: s0 = sat32((op == OP_STEP1) ? 66'(r_it.vec_a) + 66'(mr) :
                              (op == OP_STEP2) ? 66'(r_it.vec_a) - 66'(mr) :
                                                 66'(r_it.vec_c) + 66'(mr), f1);
            ST_M3: s0 = sat32((op == OP_STEP1) ? 66'(r_it.vec_b) + 66'(mr) :
                                                 66'(r_it.vec_a) - 66'(mr), f1);
            ST_M5: s0 = sat32(66'(r_t0) + 66'(mr), f1);
            default: s0 = '0;
        endcase
        s1 = sat32(66'(r_it.vec_a) + 66'(r_t0), f2);
        dq = sat32(quot, fd);
        div_start = (r_state == ST_M1) && (op == OP_BETA || op == OP_ALPHA) &&
                    !stop && r_it.divisor_value != 0;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_q_valid) n_state = ST_M1;
            ST_M1: begin
                if (op == OP_BETA || op == OP_ALPHA) begin
                    n_state = (!stop && r_it.divisor_value != 0) ? ST_DIV : ST_DONE;
                end else if (op == OP_STEP1 || op == OP_STEP2 || op == OP_STEP3) begin
                    n_state = stop ? ST_DONE : ST_M2;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_M2: n_state = ST_M3;
            ST_M3: n_state = (op == OP_STEP1) ? ST_M4 : ST_DONE;
            ST_M4: n_state = ST_M5;
            ST_M5: n_state = ST_DONE;
            ST_DIV: if (div_done) n_state = ST_DONE;
            ST_DONE: if (can_out) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            for (int i = 0; i < COLUMNS; i++) begin
                r_beta[i]  <= ONE;
                r_alpha[i] <= ONE;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && can_out) begin
                r_ov  <= 1'b1;
                r_out <= '{first_out: r_t0, second_out: r_t1,
                           skipped: r_skip, saturated: r_sat};
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
            if (r_state == ST_M1 && op == OP_RESET) begin
                r_beta[r_col]  <= ONE;
                r_alpha[r_col] <= ONE;
            end
            if (r_state == ST_DIV && div_done) begin
                if (op == OP_BETA) r_beta[r_col] <= dq;
                else               r_alpha[r_col] <= dq;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_it   <= i_q_data;
            r_col  <= col_in;
            r_sat  <= 1'b0;
        end
        if (r_state == ST_IDLE && i_q_valid) begin
            r_scal <= (i_q_data.opcode == OP_STEP1 || i_q_data.opcode == OP_BETA)
                      ? r_beta[col_in] : r_alpha[col_in];
        end
        r_prod <= 64'(mul_x) * 64'(mul_y);
        unique case (r_state)
            ST_M1: begin
                r_skip <= stop && op != OP_RESET && op != OP_UNUSED6 &&
                          op != OP_UNUSED7;
                if (op == OP_RESET) begin
                    r_t0 <= ONE; r_t1 <= '0;
                end else if (op == OP_BETA || op == OP_ALPHA) begin
                    r_t0 <= r_scal; r_t1 <= '0;
                end else if (stop && op == OP_STEP1) begin
                    r_t0 <= '0; r_t1 <= r_it.vec_c;
                end else if (stop && op == OP_STEP3) begin
                    r_t0 <= r_it.vec_c; r_t1 <= r_it.vec_a;
                end else begin
                    r_t0 <= '0; r_t1 <= '0;
                end
            end
            ST_M2: begin
                r_t0 <= s0; r_sat <= r_sat | f0 | f1;
            end
            ST_M3: begin
                if (op == OP_STEP2) begin
                    r_t1 <= s1; r_sat <= r_sat | f2;
                end else begin
                    r_t1 <= s0; r_sat <= r_sat | f0 | f1;
                end
            end
            ST_M5: begin
                r_t1 <= s0; r_sat <= r_sat | f0 | f1;
            end
            ST_DIV: if (div_done) begin
                r_t0 <= dq; r_sat <= fd;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;
endmodule

FILE: rtl/core/cgs_vector_update_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgs_vector_update_unit
// per-column alpha/beta store and cgs element updates in saturating fixed point
// ----------------------------------------------------------------------------
// input transfer to result: states M1 to M5 for step1, M1 to M3 for step2 and step3,
// M1 only for reset, stopped, unused and zero divisor items, M1 and DIV for a scalar
// divide, each followed by DONE; one item at a time in the back part: a new item is
// taken only once the last has left DONE; a two entry queue decouples the input side
// synchronous reset sets every alpha and beta to one and empties the queue.
module cgs_vector_update_unit #(
    parameter int COLUMNS       = cgs_pkg::COLUMNS_DEF,
    parameter int FRACTION_BITS = cgs_pkg::FRACTION_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  cgs_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output cgs_pkg::t_out_item o_out_data
);
    import cgs_pkg::*;

    logic     q_valid, q_pop;
    t_in_item q_data;

    cgs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_data(q_data)
    );

    cgs_back #(.COLUMNS(COLUMNS), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_data(q_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");
endmodule
